>>> src/qr_reed_solomon_parity_encoder_top_assert.svh
// assertion macros for the qr reed-solomon parity encoder
`ifndef QR_REED_SOLOMON_PARITY_ENCODER_TOP_ASSERT_SVH
`define QR_REED_SOLOMON_PARITY_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTH

`define QR_RS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("qr_rs assertion failed");

`define QR_RS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qr_rs assertion failed");

`define QR_RS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qr_rs assertion failed");

`else

`define QR_RS_ASSERT(label, clk, rst, prop)
`define QR_RS_ASSERT_IMP(label, clk, rst, ante, cons)
`define QR_RS_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/qr_rs_pkg.sv
package qr_rs_pkg;

   localparam int GEN_LIMIT = 64;
   localparam int COUNT_W = 5;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int CFG_MAX = 31;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd7;
   localparam logic [8:0] FIELD_POLY = 9'h11d;

   // register index, taken from paddr[2]
   localparam logic [0:0] REG_PARITY_COUNT = 1'b0;

   typedef logic [GEN_LIMIT:0][7:0] gen_poly_type;

   typedef struct packed {
      logic step;
      logic last;
      logic [7:0] data;
   } lfsr_cmd_type;

   // gf(256) multiply, shift and add with reduction by the field polynomial
   function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
      logic [8:0] a;
      logic [7:0] p;
      a = {1'b0, x};
      p = '0;
      for (int k = 0; k < 8; k++) begin
         if (y[k]) begin
            p = p ^ a[7:0];
         end
         a = {a[7:0], 1'b0};
         if (a[8]) begin
            a = a ^ FIELD_POLY;
         end
      end
      return p;
   endfunction

   // generator (x+a^0)..(x+a^(n-1)); entry j is the coefficient of x^(n-j)
   function automatic gen_poly_type build_gen(input int n);
      logic [7:0] asc [0:GEN_LIMIT];
      gen_poly_type g;
      logic [7:0] root;
      for (int i = 0; i <= GEN_LIMIT; i++) begin
         asc[i] = 8'd0;
      end
      asc[0] = 8'd1;
      root = 8'd1;
      for (int i = 0; i < n; i++) begin
         for (int k = i + 1; k > 0; k--) begin
            asc[k] = asc[k-1] ^ gf_mul(root, asc[k]);
         end
         asc[0] = gf_mul(root, asc[0]);
         root = gf_mul(root, 8'd2);
      end
      g = '0;
      for (int k = 0; k <= n; k++) begin
         g[k] = asc[n-k];
      end
      return g;
   endfunction

endpackage

>>> src/qr_rs_csr.sv
module qr_rs_csr #(
   parameter int MAX_PARITY = 30,
   parameter int NW = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [qr_rs_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [qr_rs_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [qr_rs_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                 csr_pready,
   output logic [NW-1:0]                        n_eff,
   output logic [MAX_PARITY:0][7:0]             gen
);

   localparam int NROWS = (MAX_PARITY < qr_rs_pkg::CFG_MAX) ? MAX_PARITY : qr_rs_pkg::CFG_MAX;
   localparam int RESET_ROW = (int'(qr_rs_pkg::COUNT_RESET) > MAX_PARITY) ?
                              MAX_PARITY : int'(qr_rs_pkg::COUNT_RESET);

   qr_rs_pkg::gen_poly_type row_tab [1:NROWS];

   logic [qr_rs_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [NW-1:0]                 n_eff_ff, n_eff_in, n_new;
   logic [MAX_PARITY:0][7:0]      gen_ff, gen_in;
   qr_rs_pkg::gen_poly_type       gen_sel;
   logic [qr_rs_pkg::COUNT_W-1:0] wv;
   logic                          wr;

   for (genvar k = 1; k <= NROWS; k++) begin : g_rows
      assign row_tab[k] = qr_rs_pkg::build_gen(k);
   end

   assign wr = csr_psel & csr_penable & csr_pwrite
               & (csr_paddr[2] == qr_rs_pkg::REG_PARITY_COUNT);
   assign wv = csr_pwdata[qr_rs_pkg::COUNT_W-1:0];

   // zero counts as one, above the maximum counts as the maximum
   always_comb begin
      if (wv == '0) begin
         n_new = NW'(1);
      end else if (int'(wv) > MAX_PARITY) begin
         n_new = NW'(MAX_PARITY);
      end else begin
         n_new = NW'(wv);
      end
   end

   always_comb begin
      gen_sel = row_tab[1];
      for (int k = 1; k <= NROWS; k++) begin
         if (n_new == NW'(k)) begin
            gen_sel = row_tab[k];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      n_eff_in = n_eff_ff;
      gen_in   = gen_ff;
      if (wr) begin
         count_in = wv;
         n_eff_in = n_new;
         gen_in   = gen_sel[MAX_PARITY:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= qr_rs_pkg::COUNT_RESET;
         n_eff_ff <= NW'(RESET_ROW);
         gen_ff   <= row_tab[RESET_ROW][MAX_PARITY:0];
      end else begin
         count_ff <= count_in;
         n_eff_ff <= n_eff_in;
         gen_ff   <= gen_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == qr_rs_pkg::REG_PARITY_COUNT) ?
                       {{(qr_rs_pkg::CSR_DW-qr_rs_pkg::COUNT_W){1'b0}}, count_ff} : '0;
   assign csr_pready = 1'b1;
   assign n_eff      = n_eff_ff;
   assign gen        = gen_ff;

endmodule

>>> src/qr_rs_lfsr.sv
module qr_rs_lfsr #(
   parameter int MAX_PARITY = 30,
   parameter int NW = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qr_rs_pkg::lfsr_cmd_type       cmd,
   input  logic [NW-1:0]                 n_eff,
   input  logic [MAX_PARITY:0][7:0]      gen,
   output logic [MAX_PARITY-1:0][7:0]    rem_upd
);

   logic [MAX_PARITY-1:0][7:0] rem_ff, rem_in;
   logic [7:0]                 fb;

   assign fb = cmd.data ^ rem_ff[0];

   // entry 0 is the highest coefficient; entries at n and above are held
   for (genvar i = 0; i < MAX_PARITY; i++) begin : g_tap
      logic [7:0] prod;
      logic [7:0] shifted;
      assign prod = qr_rs_pkg::gf_mul(fb, gen[i+1]);
      if (i < MAX_PARITY - 1) begin : g_mid
         assign shifted = rem_ff[i+1];
      end else begin : g_top
         assign shifted = 8'd0;
      end
      always_comb begin
         if (NW'(i + 1) < n_eff) begin
            rem_upd[i] = shifted ^ prod;
         end else if (NW'(i + 1) == n_eff) begin
            rem_upd[i] = prod;
         end else begin
            rem_upd[i] = rem_ff[i];
         end
      end
   end

   always_comb begin
      rem_in = rem_ff;
      if (cmd.step) begin
         rem_in = cmd.last ? '0 : rem_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

endmodule

>>> src/qr_reed_solomon_parity_encoder_top.sv
// a data byte is registered and appears on the result channel in the cycle after its transfer
// throughput: one data byte per cycle while rsp_ready is high; after a last byte the n parity
//   bytes follow one per cycle, and req_ready stays low while parity bytes are still queued
// the rate is set by the combinational remainder update and the one output register
// reset (synchronous, active high): remainder cleared, parity count 7, outputs empty
`include "qr_reed_solomon_parity_encoder_top_assert.svh"

module qr_reed_solomon_parity_encoder_top #(
   parameter int MAX_PARITY = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   // input data stream
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_data,
   // codeword stream
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_code_byte,
   output logic                          rsp_is_parity,
   output logic                          rsp_last_out,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [qr_rs_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [qr_rs_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [qr_rs_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready
);

   // enough bits to hold the parity count itself
   localparam int NW = $clog2(MAX_PARITY + 1);

   logic [NW-1:0]                 n_eff;
   logic [MAX_PARITY:0][7:0]      gen;
   logic [MAX_PARITY-1:0][7:0]    rem_upd;
   qr_rs_pkg::lfsr_cmd_type       cmd;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_parity_ff, out_parity_in;
   logic       out_last_ff, out_last_in;

   // parity bytes still to go out, highest degree in entry 0
   logic [MAX_PARITY-1:0][7:0] par_ff, par_in;
   logic [NW-1:0]              par_left_ff, par_left_in;

   logic out_free;
   logic in_xfer;

   qr_rs_csr #(
      .MAX_PARITY (MAX_PARITY),
      .NW         (NW)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .n_eff       (n_eff),
      .gen         (gen)
   );

   // the output register can take a new byte when empty or being drained
   assign out_free  = !out_valid_ff || rsp_ready;
   // parity bytes have priority over new data
   assign req_ready = out_free && (par_left_ff == '0);
   assign in_xfer   = req_valid && req_ready;

   assign cmd.step = in_xfer;
   assign cmd.last = req_last_data;
   assign cmd.data = req_data_byte;

   qr_rs_lfsr #(
      .MAX_PARITY (MAX_PARITY),
      .NW         (NW)
   ) u_lfsr (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .n_eff   (n_eff),
      .gen     (gen),
      .rem_upd (rem_upd)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_parity_in = out_parity_ff;
      out_last_in   = out_last_ff;
      par_in        = par_ff;
      par_left_in   = par_left_ff;
      if (out_free) begin
         if (par_left_ff != '0) begin
            // next parity byte, shift the queue up
            out_valid_in  = 1'b1;
            out_byte_in   = par_ff[0];
            out_parity_in = 1'b1;
            out_last_in   = (par_left_ff == NW'(1));
            par_in        = {8'd0, par_ff[MAX_PARITY-1:1]};
            par_left_in   = par_left_ff - NW'(1);
         end else if (req_valid) begin
            // data byte goes straight through
            out_valid_in  = 1'b1;
            out_byte_in   = req_data_byte;
            out_parity_in = 1'b0;
            out_last_in   = 1'b0;
            if (req_last_data) begin
               // snapshot of the final remainder is the parity block
               par_in      = rem_upd;
               par_left_in = n_eff;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         par_left_ff  <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         par_left_ff  <= par_left_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_parity_ff <= out_parity_in;
      out_last_ff   <= out_last_in;
      par_ff        <= par_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_code_byte = out_byte_ff;
   assign rsp_is_parity = out_parity_ff;
   assign rsp_last_out  = out_last_ff;

   // no data transfer while parity is still queued
   `QR_RS_ASSERT_IMP(a_no_data_in_parity, clock, reset, in_xfer, par_left_ff == '0)
   // the final byte of a codeword is always a parity byte
   `QR_RS_ASSERT_IMP(a_last_is_parity, clock, reset, out_valid_ff && out_last_ff, out_parity_ff)
   // a last data byte queues exactly n parity bytes
   `QR_RS_ASSERT_NXT(a_parity_load, clock, reset, in_xfer && req_last_data, par_left_ff == $past(n_eff))
   // each free output slot drains one queued parity byte
   `QR_RS_ASSERT_NXT(a_parity_drain, clock, reset, out_free && (par_left_ff != '0), out_parity_ff && (par_left_ff == $past(par_left_ff) - NW'(1)))

endmodule

>>> tb/tb_qr_reed_solomon_parity_encoder_top.sv
module tb_qr_reed_solomon_parity_encoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PARITY = 30;
   localparam int RANDOM_ITEMS = 300;
   // worst case is far below this: every byte a block end at 30 parity bytes,
   // every transfer waiting out the longest gap or stall
   localparam int CYCLE_LIMIT = 800000;
   // low byte of the field polynomial, folded back in on each doubling
   localparam logic [7:0] POLY_LOW = 8'h1d;
   localparam logic [qr_rs_pkg::CSR_AW-1:0] COUNT_ADDR =
      {qr_rs_pkg::REG_PARITY_COUNT, 2'b00};
   // next word up decodes to a register index that does not exist
   localparam logic [qr_rs_pkg::CSR_AW-1:0] UNUSED_ADDR =
      {~qr_rs_pkg::REG_PARITY_COUNT, 2'b00};

   typedef struct packed {
      logic [7:0] code_byte;
      logic       is_parity;
      logic       last_out;
   } codeword_type;

   // every block input starts at a known value
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_data_byte = 8'd0;
   logic                           req_last_data = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [7:0]                     rsp_code_byte;
   logic                           rsp_is_parity;
   logic                           rsp_last_out;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [qr_rs_pkg::CSR_AW-1:0]   csr_paddr = '0;
   logic [qr_rs_pkg::CSR_DW-1:0]   csr_pwdata = '0;
   logic [qr_rs_pkg::CSR_DW-1:0]   csr_prdata;
   logic                           csr_pready;

   // predictor state: lfsr remainder (entry 0 is the highest degree) and parity count
   logic [7:0]                     rs_remainder [0:MAX_PARITY-1];
   logic [qr_rs_pkg::COUNT_W-1:0]  rs_count;
   codeword_type                   pending_codewords [$];

   int mismatches = 0;
   int cycles = 0;
   int items_sent = 0;
   int stall_left = 0;
   bit sender_idle = 1'b1;
   bit receiver_idle = 1'b1;

   qr_reed_solomon_parity_encoder_top #(
      .MAX_PARITY(MAX_PARITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last_data(req_last_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_code_byte(rsp_code_byte),
      .rsp_is_parity(rsp_is_parity),
      .rsp_last_out(rsp_last_out),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_qr_reed_solomon_parity_encoder_top NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // gf(256) product by repeated doubling of a
   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'd0;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         x = x[7] ? ({x[6:0], 1'b0} ^ POLY_LOW) : {x[6:0], 1'b0};
      end
      return acc;
   endfunction

   // parity count as the block uses it: zero reads as one, anything above the
   // array size as the array size
   function automatic int active_count();
      int n;
      n = int'(rs_count);
      if (n < 1) begin
         n = 1;
      end
      if (n > MAX_PARITY) begin
         n = MAX_PARITY;
      end
      return n;
   endfunction

   // one expected codeword at the back of the scoreboard
   function automatic void queue_codeword(input logic [7:0] code, input logic parity,
                                          input logic last);
      codeword_type item;
      item = codeword_type'{code_byte: code, is_parity: parity, last_out: last};
      pending_codewords = {pending_codewords, item};
   endfunction

   // one accepted byte: queue its pass-through codeword, step the remainder and,
   // at a block end, queue the parity bytes highest first and clear everything
   task automatic encode_byte(input logic [7:0] d, input logic is_last);
      logic [7:0] g [0:MAX_PARITY];
      logic [7:0] root;
      logic [7:0] fb;
      int n;
      n = active_count();
      // generator in descending order, g[0] the monic leading term,
      // built up one root (x + alpha^i) at a time
      for (int k = 0; k <= MAX_PARITY; k++) begin
         g[k] = 8'd0;
      end
      g[0] = 8'd1;
      root = 8'd1;
      for (int i = 0; i < n; i++) begin
         for (int k = i + 1; k > 0; k--) begin
            g[k] = g[k] ^ gf_times(root, g[k-1]);
         end
         root = gf_times(root, 8'd2);
      end
      queue_codeword(d, 1'b0, 1'b0);
      fb = d ^ rs_remainder[0];
      for (int i = 0; i < n - 1; i++) begin
         rs_remainder[i] = rs_remainder[i+1] ^ gf_times(fb, g[i+1]);
      end
      rs_remainder[n-1] = gf_times(fb, g[n]);
      if (is_last) begin
         for (int i = 0; i < n; i++) begin
            queue_codeword(rs_remainder[i], 1'b1, (i == n - 1));
         end
         // entries beyond the active count are cleared too
         for (int i = 0; i < MAX_PARITY; i++) begin
            rs_remainder[i] = 8'd0;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // result side: random back-pressure and the checker
   // ---------------------------------------------------------------------

   // after a transfer the receiver may hold off, when receiver idling is on
   always @(posedge clock) begin : result_stall
      int draw;
      if (reset) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) begin
            rsp_ready <= 1'b1;
         end
      end else if (rsp_valid && rsp_ready && receiver_idle) begin
         draw = $urandom_range(0, 16);
         if (draw > 0) begin
            rsp_ready <= 1'b0;
            stall_left = draw;
         end
      end else if (!rsp_ready) begin
         rsp_ready <= 1'b1;
      end
   end

   // each codeword transfer against the oldest expectation, field by field
   always @(posedge clock) begin : result_check
      codeword_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codewords.size() == 0) begin
            mismatches++;
            $display("%0t: codeword with nothing expected: byte %h parity %b last %b",
                     $time, rsp_code_byte, rsp_is_parity, rsp_last_out);
         end else begin
            want = pending_codewords.pop_front();
            if (rsp_code_byte !== want.code_byte) begin
               mismatches++;
               $display("%0t: code_byte expected %h actual %h",
                        $time, want.code_byte, rsp_code_byte);
            end
            if (rsp_is_parity !== want.is_parity) begin
               mismatches++;
               $display("%0t: is_parity expected %b actual %b",
                        $time, want.is_parity, rsp_is_parity);
            end
            if (rsp_last_out !== want.last_out) begin
               mismatches++;
               $display("%0t: last_out expected %b actual %b",
                        $time, want.last_out, rsp_last_out);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // driver tasks
   // ---------------------------------------------------------------------

   // one data byte; valid stays high across back-to-back transfers and is
   // only dropped for a gap or by drain_codewords
   task automatic send_byte(input logic [7:0] d, input logic is_last);
      int gap;
      gap = sender_idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_last_data <= is_last;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      encode_byte(d, is_last);
      items_sent++;
   endtask

   // stop sending and let every expected codeword arrive, plus a short margin
   task automatic drain_codewords();
      req_valid <= 1'b0;
      while (pending_codewords.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   // setup then access cycle; upper data bits are random, only the count field counts
   task automatic write_count_reg(input logic [qr_rs_pkg::CSR_AW-1:0] addr,
                                  input logic [qr_rs_pkg::COUNT_W-1:0] value);
      logic [qr_rs_pkg::CSR_DW-1:0] word;
      word = $urandom();
      word[qr_rs_pkg::COUNT_W-1:0] = value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == COUNT_ADDR) begin
         rs_count = value;
      end
      // bus goes idle before the next access
      @(posedge clock);
   endtask

   task automatic check_count_reg();
      logic [qr_rs_pkg::CSR_DW-1:0] word;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= COUNT_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      word = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (word[qr_rs_pkg::COUNT_W-1:0] !== rs_count) begin
         mismatches++;
         $display("%0t: parity_count read expected %0d actual %0d",
                  $time, rs_count, word[qr_rs_pkg::COUNT_W-1:0]);
      end
      // bus goes idle before the next access
      @(posedge clock);
   endtask

   // random block; a non-zero split point drains there and changes the count
   // in the middle of the block
   task automatic send_block(input int len, input int split_at,
                             input logic [qr_rs_pkg::COUNT_W-1:0] split_count);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
         if (i + 1 == split_at) begin
            drain_codewords();
            write_count_reg(COUNT_ADDR, split_count);
         end
      end
   endtask

   // register values leaning on the edges of the range and beyond it
   function automatic logic [qr_rs_pkg::COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0: return 5'd0;
         1: return 5'd31;
         2: return 5'd1;
         3: return 5'd30;
         default: return 5'($urandom_range(1, 30));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset count of seven, no idling on either side
   task automatic test_reset_default();
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      check_count_reg();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      drain_codewords();
   endtask

   // all-zero, all-one, single-bit and single-zero-bit bytes, then a one-byte block
   task automatic test_byte_extremes();
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'hfe, 1'b1);
      send_byte(8'ha5, 1'b1);
      drain_codewords();
   endtask

   // smallest and largest counts, and the two values that get clamped
   task automatic test_count_limits();
      write_count_reg(COUNT_ADDR, 5'd1);
      check_count_reg();
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);
      drain_codewords();
      write_count_reg(COUNT_ADDR, 5'd30);
      send_byte(8'hc3, 1'b0);
      send_byte(8'h3c, 1'b0);
      send_byte(8'h55, 1'b1);
      drain_codewords();
      // zero behaves as one
      write_count_reg(COUNT_ADDR, 5'd0);
      check_count_reg();
      send_byte(8'h9a, 1'b1);
      drain_codewords();
      // 31 behaves as the array size
      write_count_reg(COUNT_ADDR, 5'd31);
      check_count_reg();
      sender_idle = 1'b0;
      send_byte(8'hde, 1'b0);
      send_byte(8'had, 1'b1);
      drain_codewords();
   endtask

   // count changed twice inside one block: remainder carries over as it stands
   task automatic test_count_change_mid_block();
      sender_idle = 1'b1;
      write_count_reg(COUNT_ADDR, 5'd12);
      send_byte(8'h5a, 1'b0);
      send_byte(8'ha5, 1'b0);
      drain_codewords();
      write_count_reg(COUNT_ADDR, 5'd3);
      send_byte(8'h0f, 1'b0);
      drain_codewords();
      write_count_reg(COUNT_ADDR, 5'd20);
      send_byte(8'hf0, 1'b1);
      drain_codewords();
   endtask

   // write to a register index that does not exist must leave the count alone
   task automatic test_ignored_index();
      write_count_reg(UNUSED_ADDR, 5'd5);
      check_count_reg();
      send_byte(8'h77, 1'b1);
      drain_codewords();
   endtask

   // blocks of random length and content, back to back, with count changes
   // between blocks and now and then inside one
   task automatic test_random_blocks();
      int first;
      int len;
      int split_at;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         // idling comes and goes in stretches on each side
         sender_idle = $urandom_range(0, 3) != 0;
         receiver_idle = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 2) == 0) begin
            drain_codewords();
            write_count_reg(COUNT_ADDR, pick_count());
            if ($urandom_range(0, 3) == 0) begin
               check_count_reg();
            end
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         split_at = 0;
         if (len > 1 && $urandom_range(0, 7) == 0) begin
            split_at = $urandom_range(1, len - 1);
         end
         send_block(len, split_at, pick_count());
      end
      drain_codewords();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      rs_count = qr_rs_pkg::COUNT_RESET;
      for (int i = 0; i < MAX_PARITY; i++) begin
         rs_remainder[i] = 8'd0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_default();
      test_byte_extremes();
      test_count_limits();
      test_count_change_mid_block();
      test_ignored_index();
      test_random_blocks();

      // nothing left outstanding; give a stray late transfer time to show up
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_qr_reed_solomon_parity_encoder_top OK");
      end else begin
         $display("tb_qr_reed_solomon_parity_encoder_top NOT OK");
      end
      $finish;
   end

endmodule

>>> qr_reed_solomon_parity_encoder_top.f
+incdir+src
src/qr_rs_pkg.sv
src/qr_rs_csr.sv
src/qr_rs_lfsr.sv
src/qr_reed_solomon_parity_encoder_top.sv
tb/tb_qr_reed_solomon_parity_encoder_top.sv
